// ===== rtl/ehcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ehcm_pkg: shared types and constants
// Payload structs, compare result and fixed constants of the echo/Hall
// capture median filter.
// ----------------------------------------------------------------------------
package ehcm_pkg;

	localparam int ECHO_CH          = 5;
	localparam int HALL_CH          = 2;
	localparam int ECHO_WINDOW_DEF  = 8;
	localparam int HALL_WINDOW_DEF  = 8;

	localparam logic [15:0] ECHO_MAX_W = 16'd12000;
	localparam logic [14:0] DIV59_K    = 15'd17773;  // ceil(2^20 / 59)
	localparam int          DIV59_S    = 20;
	localparam logic [7:0]  ECHO_INIT  = 8'd200;
	localparam logic [31:0] HALL_INIT  = 32'hFFFF_FFFF;
	localparam logic [9:0]  NEAR_RST   = 10'd30;
	localparam logic [9:0]  FAR_RST    = 10'd100;

	// register index, taken from paddr[2]
	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_FAR  = 1'b1;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_HALL = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  sensor_channel;
		logic        edge_level;
		logic [31:0] capture_time;
	} ehcm_req_t;

	typedef struct packed {
		logic        new_measurement;
		logic        result_kind;
		logic [2:0]  result_channel;
		logic [31:0] median_value;
		logic [4:0]  near_map;
		logic [4:0]  far_map;
	} ehcm_rsp_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} ehcm_cmp_t;

endpackage

// ===== rtl/ehcm_cmp.sv =====
// ----------------------------------------------------------------------------
// ehcm_cmp: shared magnitude comparator
// One 32-bit unsigned compare, used by both the rank sweep and the vote.
// ----------------------------------------------------------------------------
module ehcm_cmp
	import ehcm_pkg::*;
(
	input  logic [31:0] a,
	input  logic [31:0] b,
	output ehcm_cmp_t   res
);

	assign res.gt = (a > b);
	assign res.eq = (a == b);

endmodule

// ===== rtl/ehcm_div59.sv =====
// ----------------------------------------------------------------------------
// ehcm_div59: pulse width to centimeters
// Divide a width below 12000 by 59 with a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module ehcm_div59
	import ehcm_pkg::*;
(
	input  logic        clk,
	input  logic [13:0] width,
	output logic [7:0]  quot
);

	logic [28:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {15'd0, width} * {14'd0, DIV59_K};
	end

	assign quot = prod_q[DIV59_S+7:DIV59_S];

endmodule

// ===== rtl/echo_hall_capture_median_filter.sv =====
// ----------------------------------------------------------------------------
// echo_hall_capture_median_filter: capture edges, sliding median, obstacle maps
// Top level with sequencer, window storage and the APB register port.
// ----------------------------------------------------------------------------
// One transaction on req is processed at a time; req_ready is high only while
// the sequencer is idle. Every event runs the vote, which walks every echo
// entry twice through the single shared comparator, once against each limit.
// An event that completes a measurement first runs the push, the row load and
// the rank sweep, which compares every entry against every candidate through
// the same comparator; an echo channel also runs the divide, which a Hall
// channel skips. The result sits in an output register, so a stalled rsp side
// does not hold up the sequencer until the next result is ready. Windows live
// in flip-flops and come out of reset full of their reset values at once;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module echo_hall_capture_median_filter
	import ehcm_pkg::*;
#(
	parameter int ECHO_WINDOW = ECHO_WINDOW_DEF,
	parameter int HALL_WINDOW = HALL_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  ehcm_req_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output ehcm_rsp_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NB      = (ECHO_WINDOW > HALL_WINDOW) ? ECHO_WINDOW : HALL_WINDOW;
	localparam int CNT_W   = $clog2(NB + 1);
	localparam int EFILL_W = $clog2(ECHO_WINDOW + 1);
	localparam int HFILL_W = $clog2(HALL_WINDOW + 1);
	localparam logic [CNT_W-1:0] VOTE_MIN = CNT_W'(ECHO_WINDOW / 2);
	localparam logic EODD = ECHO_WINDOW % 2 == 1;
	localparam logic HODD = HALL_WINDOW % 2 == 1;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CALC  = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_PUSH  = 9'b000001000,
		ST_LOAD  = 9'b000010000,
		ST_RANK  = 9'b000100000,
		ST_VLOAD = 9'b001000000,
		ST_VOTE  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [9:0] near_q, far_q;

	// channel state
	logic               earmed_q [ECHO_CH];
	logic [15:0]        estart_q [ECHO_CH];
	logic [EFILL_W-1:0] efill_q  [ECHO_CH];
	logic [7:0]         ewin_q   [ECHO_CH][ECHO_WINDOW];
	logic               harmed_q [HALL_CH];
	logic [31:0]        hstart_q [HALL_CH];
	logic [HFILL_W-1:0] hfill_q  [HALL_CH];
	logic [31:0]        hwin_q   [HALL_CH][HALL_WINDOW];

	// work registers
	ehcm_req_t        req_q;
	logic             fresh_q;
	logic [13:0]      w_q;
	logic [31:0]      val_q;
	logic [31:0]      buf_q [NB];
	logic [31:0]      cand_q;
	logic [CNT_W-1:0] n_q, ridx_q, cidx_q, cnt_gt_q, cnt_eq_q;
	logic [31:0]      med_hi_q, med_lo_q;
	logic [2:0]       vj_q;
	logic             phase_q;
	logic [4:0]       nmap_q, fmap_q;

	// output register
	logic      rsp_valid_q;
	ehcm_rsp_t rsp_q;

	logic [2:0] ech;
	logic       hch;
	assign ech = req_q.sensor_channel;
	assign hch = req_q.sensor_channel[0];

	// width of the echo pulse, wrapping at 16 bits
	logic [15:0] t16, est, w16;
	assign t16 = req_q.capture_time[15:0];
	assign est = estart_q[ech];
	assign w16 = (t16 > est) ? (t16 - est - 16'd1) : (t16 - est);

	logic [31:0] hst, per;
	assign hst = hstart_q[hch];
	assign per = (req_q.capture_time >= hst) ? (req_q.capture_time - hst - 32'd1)
	                                         : (req_q.capture_time - hst);

	logic [7:0] cm;
	ehcm_div59 u_div (
		.clk   (clk),
		.width (w_q),
		.quot  (cm)
	);

	// shared compare unit: rank sweep or limit vote
	logic [31:0] cmp_a, cmp_b;
	ehcm_cmp_t   cres;
	always_comb begin
		if (state_q == ST_RANK) begin
			cmp_a = buf_q[0];
			cmp_b = cand_q;
		end else begin
			cmp_a = {22'd0, phase_q ? far_q : near_q};
			cmp_b = buf_q[0];
		end
	end

	ehcm_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cres)
	);

	logic [CNT_W-1:0] last_idx, gt_tot, eq_tot, pos_hi, pos_lo;
	logic             hit_hi, hit_lo, lap_end;
	assign last_idx = n_q - CNT_W'(1);
	assign lap_end  = (ridx_q == last_idx);
	assign gt_tot   = cnt_gt_q + CNT_W'(cres.gt);
	assign eq_tot   = cnt_eq_q + CNT_W'(cres.eq);
	assign pos_hi   = n_q >> 1;
	assign pos_lo   = pos_hi - CNT_W'(1);
	assign hit_hi   = (gt_tot <= pos_hi) && (pos_hi < gt_tot + eq_tot);
	assign hit_lo   = (gt_tot <= pos_lo) && (pos_lo < gt_tot + eq_tot);

	logic [32:0] med_sum;
	logic [31:0] med;
	logic        odd;
	assign med_sum = {1'b0, med_hi_q} + {1'b0, med_lo_q};
	assign odd     = (req_q.req_type == KIND_HALL) ? HODD : EODD;
	assign med     = odd ? med_hi_q : med_sum[32:1];

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RST;
			far_q  <= FAR_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_NEAR: near_q <= pwdata[9:0];
				REG_FAR:  far_q  <= pwdata[9:0];
				default:  near_q <= near_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NEAR: prdata = {22'd0, near_q};
			REG_FAR:  prdata = {22'd0, far_q};
			default:  prdata = 32'd0;
		endcase
	end
	assign pready = 1'b1;

	// sequencer, channel state and windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fresh_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int c = 0; c < ECHO_CH; c++) begin
				earmed_q[c] <= 1'b0;
				estart_q[c] <= 16'd0;
				efill_q[c]  <= '0;
				for (int k = 0; k < ECHO_WINDOW; k++) ewin_q[c][k] <= ECHO_INIT;
			end
			for (int c = 0; c < HALL_CH; c++) begin
				harmed_q[c] <= 1'b0;
				hstart_q[c] <= 32'd0;
				hfill_q[c]  <= '0;
				for (int k = 0; k < HALL_WINDOW; k++) hwin_q[c][k] <= HALL_INIT;
			end
		end else begin
			// drop the result once taken, unless a new one loads in this cycle
			if (rsp_valid_q && rsp_ready && state_q != ST_DONE) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					fresh_q <= 1'b0;
					state_q <= ST_VLOAD;
					vj_q    <= 3'd0;
					phase_q <= 1'b0;
					if (req_q.req_type == KIND_ECHO) begin
						if (ech < 3'(ECHO_CH)) begin
							if (req_q.edge_level) begin
								earmed_q[ech] <= 1'b1;
								estart_q[ech] <= t16;
							end else if (earmed_q[ech]) begin
								earmed_q[ech] <= 1'b0;
								if (w16 < ECHO_MAX_W) begin
									w_q     <= w16[13:0];
									fresh_q <= 1'b1;
									state_q <= ST_DIV;
								end
							end
						end
					end else if (req_q.sensor_channel < 3'(HALL_CH)) begin
						if (!harmed_q[hch]) begin
							harmed_q[hch] <= 1'b1;
							hstart_q[hch] <= req_q.capture_time;
						end else begin
							harmed_q[hch] <= 1'b0;
							val_q         <= per;
							fresh_q       <= 1'b1;
							state_q       <= ST_PUSH;
						end
					end
				end
				ST_DIV: begin
					// product registers in this cycle
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (req_q.req_type == KIND_ECHO) begin
						if (efill_q[ech] < EFILL_W'(ECHO_WINDOW)) begin
							for (int k = 0; k < ECHO_WINDOW; k++)
								if (EFILL_W'(k) == efill_q[ech]) ewin_q[ech][k] <= cm;
							efill_q[ech] <= efill_q[ech] + EFILL_W'(1);
						end else begin
							for (int k = 0; k < ECHO_WINDOW - 1; k++)
								ewin_q[ech][k] <= ewin_q[ech][k+1];
							ewin_q[ech][ECHO_WINDOW-1] <= cm;
						end
					end else begin
						if (hfill_q[hch] < HFILL_W'(HALL_WINDOW)) begin
							for (int k = 0; k < HALL_WINDOW; k++)
								if (HFILL_W'(k) == hfill_q[hch]) hwin_q[hch][k] <= val_q;
							hfill_q[hch] <= hfill_q[hch] + HFILL_W'(1);
						end else begin
							for (int k = 0; k < HALL_WINDOW - 1; k++)
								hwin_q[hch][k] <= hwin_q[hch][k+1];
							hwin_q[hch][HALL_WINDOW-1] <= val_q;
						end
					end
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (req_q.req_type == KIND_ECHO) begin
						for (int k = 0; k < ECHO_WINDOW; k++) buf_q[k] <= {24'd0, ewin_q[ech][k]};
						cand_q <= {24'd0, ewin_q[ech][0]};
						n_q    <= CNT_W'(ECHO_WINDOW);
					end else begin
						for (int k = 0; k < HALL_WINDOW; k++) buf_q[k] <= hwin_q[hch][k];
						cand_q <= hwin_q[hch][0];
						n_q    <= CNT_W'(HALL_WINDOW);
					end
					ridx_q   <= '0;
					cidx_q   <= '0;
					cnt_gt_q <= '0;
					cnt_eq_q <= '0;
					state_q  <= ST_RANK;
				end
				ST_RANK: begin
					// rotate the window past the candidate; count larger and equal.
					// Hold it on the last compare of a lap, so the next lap starts one
					// entry earlier and that entry becomes the next candidate.
					if (!lap_end) begin
						for (int k = 0; k < NB - 1; k++)
							buf_q[k] <= (CNT_W'(k) == last_idx) ? buf_q[0] : buf_q[k+1];
						buf_q[NB-1] <= buf_q[0];
					end
					if (lap_end) begin
						if (hit_hi) med_hi_q <= cand_q;
						if (hit_lo) med_lo_q <= cand_q;
						cand_q   <= buf_q[0];
						ridx_q   <= '0;
						cnt_gt_q <= '0;
						cnt_eq_q <= '0;
						if (cidx_q == last_idx) state_q <= ST_VLOAD;
						else cidx_q <= cidx_q + CNT_W'(1);
					end else begin
						ridx_q   <= ridx_q + CNT_W'(1);
						cnt_gt_q <= gt_tot;
						cnt_eq_q <= eq_tot;
					end
				end
				ST_VLOAD: begin
					for (int k = 0; k < ECHO_WINDOW; k++) buf_q[k] <= {24'd0, ewin_q[vj_q][k]};
					n_q      <= CNT_W'(ECHO_WINDOW);
					ridx_q   <= '0;
					cnt_gt_q <= '0;
					state_q  <= ST_VOTE;
				end
				ST_VOTE: begin
					for (int k = 0; k < NB - 1; k++)
						buf_q[k] <= (CNT_W'(k) == last_idx) ? buf_q[0] : buf_q[k+1];
					buf_q[NB-1] <= buf_q[0];
					if (lap_end) begin
						ridx_q   <= '0;
						cnt_gt_q <= '0;
						if (!phase_q) begin
							nmap_q[vj_q] <= (gt_tot >= VOTE_MIN);
							phase_q      <= 1'b1;
						end else begin
							fmap_q[vj_q] <= (gt_tot >= VOTE_MIN);
							phase_q      <= 1'b0;
							if (vj_q == 3'(ECHO_CH - 1)) state_q <= ST_DONE;
							else begin
								vj_q    <= vj_q + 3'd1;
								state_q <= ST_VLOAD;
							end
						end
					end else begin
						ridx_q   <= ridx_q + CNT_W'(1);
						cnt_gt_q <= gt_tot;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.new_measurement <= fresh_q;
						rsp_q.result_kind     <= req_q.req_type;
						rsp_q.result_channel  <= req_q.sensor_channel;
						rsp_q.median_value    <= fresh_q ? med : 32'd0;
						rsp_q.near_map        <= nmap_q;
						rsp_q.far_map         <= fmap_q;
						rsp_valid_q           <= 1'b1;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/ehcm_checker.sv =====
// ----------------------------------------------------------------------------
// ehcm_checker: port-level assertions
// Checks sequencing and result sanity seen on the top level's channels.
// ----------------------------------------------------------------------------
module ehcm_checker
	import ehcm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input ehcm_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after an accepted transaction");

	a_no_meas: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.new_measurement |-> rsp.median_value == 32'd0)
		else $error("median given without a measurement");

	a_echo_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.new_measurement && rsp.result_kind == KIND_ECHO
		|-> rsp.median_value < 32'd204 && rsp.result_channel < 3'd5)
		else $error("echo median out of range");

endmodule

bind echo_hall_capture_median_filter ehcm_checker u_ehcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
